@@ hdl/cps_pkg.sv @@
// package for the closest pair search block: sizes, payload types, sequencer states
// no dependencies; compile first

package cps_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;

	localparam int IDX_BITS  = $clog2(MAX_POINTS);
	localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
	localparam int DIFF_BITS = COORD_BITS;
	localparam int SQ_BITS   = 2 * DIFF_BITS;
	localparam int DIST_BITS = SQ_BITS + 1;
	localparam int WORD_BITS = 2 * COORD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic [DIST_BITS-1:0]         dist_t;

	// one pair on its way through the distance unit
	typedef struct packed {
		logic valid;
		idx_t first;
		idx_t second;
	} pair_tok_t;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic               found;
		logic [5:0]         first_index;
		logic [5:0]         second_index;
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic [32:0]        min_dist_sq;
		logic               overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEARCH,
		ST_DRAIN,
		ST_FETCH,
		ST_CAPTURE
	} state_t;

endpackage

@@ hdl/cps_point_if.sv @@
// stream interface for the point channel
// depends on cps_pkg

interface cps_point_if;
	logic            valid;
	logic            ready;
	cps_pkg::point_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/cps_result_if.sv @@
// stream interface for the result channel
// depends on cps_pkg

interface cps_result_if;
	logic             valid;
	logic             ready;
	cps_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/closest_pair_search.sv @@
// closest pair search, top level: point store, pair sequencer, best pair tracking
// depends on cps_pkg, cps_point_if, cps_result_if, cps_ram, cps_dist_unit
//
// usage
//   points: one 2-d point per transfer, written to the store in arrival order.
//     the transfer with last_point set closes the set and starts the search.
//     up to MAX_POINTS (64) points are kept; later ones are dropped and the
//     overflow field of the result is set. a dropped last point still starts
//     the search over the points already stored.
//   result: one transfer per set, with the indices and coordinates of the
//     closest pair (ties keep the earliest pair in i-outer, j-inner order)
//     and its squared distance. with fewer than two points found is 0 and
//     all other fields but overflow are 0.
// timing
//   points are loaded one per cycle while points ready stays high.
//   after the last point, points ready drops while the sequencer feeds one
//   pair per cycle into the shared distance unit, n*(n-1)/2 pairs for n
//   points; then the unit drains, the winning coordinates are fetched and
//   the result is loaded. with under two points the search and the drain
//   are skipped.
// reset and stall
//   arst_n clears the count, flags, best pair and the result valid flag; the
//   store itself is not cleared. a result waits in its output register while
//   the receiver stalls; the next set may load meanwhile, and its result is
//   held back at the fetch step until the previous one has been taken.

module closest_pair_search (
	input logic        clk,
	input logic        arst_n,
	cps_point_if.sink  points,
	cps_result_if.source result
);

	cps_pkg::state_t    state_q, state_d;

	cps_pkg::cnt_t      cnt_q;      // points loaded in the current set
	cps_pkg::cnt_t      n_q;        // points in the set being searched
	logic               ovf_q;      // current set dropped a point
	logic               ovf_res_q;  // overflow of the set being searched
	logic               found_q;
	cps_pkg::idx_t      i_q, j_q;

	cps_pkg::idx_t      best_first_q, best_second_q;
	cps_pkg::dist_t     best_dist_q;
	logic               best_any_q;

	logic               out_valid_q;
	cps_pkg::result_t   out_q;

	// handshake and load decode
	logic               in_acc, last_acc, cnt_full, store_we;
	cps_pkg::cnt_t      cnt_next;
	logic               j_end, pair_last;

	// sequencer outputs
	logic               in_ready, issue, fetch_go, capture;

	// store read side
	cps_pkg::idx_t      raddr_a, raddr_b;
	logic [cps_pkg::WORD_BITS-1:0] wdata, rdata_a, rdata_b;
	cps_pkg::coord_t    ax_s1, ay_s1, bx_s1, by_s1;
	cps_pkg::pair_tok_t tok_s1, tok_s3;
	cps_pkg::dist_t     dist_s3;
	logic               unit_busy;

	assign in_acc   = points.valid & in_ready;
	assign last_acc = in_acc & points.data.last_point;
	assign cnt_full = (cnt_q == cps_pkg::CNT_BITS'(cps_pkg::MAX_POINTS));
	assign store_we = in_acc & ~cnt_full;
	assign cnt_next = cnt_full ? cnt_q : cnt_q + 1'b1;

	// last pair of a row, and the very last pair of the search
	assign j_end     = (cps_pkg::CNT_BITS'(j_q) + 1'b1) == n_q;
	assign pair_last = j_end && ((cps_pkg::CNT_BITS'(i_q) + 2'd2) == n_q);

	// coordinates wrapped to the store width, y above x
	assign wdata = {cps_pkg::coord_t'(points.data.point_y),
		cps_pkg::coord_t'(points.data.point_x)};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cps_pkg::ST_LOAD: begin
				if (last_acc) begin
					state_d = (cnt_next >= cps_pkg::CNT_BITS'(2)) ? cps_pkg::ST_SEARCH
						: cps_pkg::ST_FETCH;
				end
			end
			cps_pkg::ST_SEARCH: begin
				if (pair_last) begin
					state_d = cps_pkg::ST_DRAIN;
				end
			end
			cps_pkg::ST_DRAIN: begin
				if (!tok_s1.valid && !unit_busy) begin
					state_d = cps_pkg::ST_FETCH;
				end
			end
			cps_pkg::ST_FETCH: begin
				if (!out_valid_q || result.ready) begin
					state_d = cps_pkg::ST_CAPTURE;
				end
			end
			cps_pkg::ST_CAPTURE: begin
				state_d = cps_pkg::ST_LOAD;
			end
			default: state_d = cps_pkg::ST_LOAD;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		fetch_go = 1'b0;
		capture  = 1'b0;
		unique case (state_q)
			cps_pkg::ST_LOAD:    in_ready = 1'b1;
			cps_pkg::ST_SEARCH:  issue    = 1'b1;
			cps_pkg::ST_DRAIN:   ;
			cps_pkg::ST_FETCH:   fetch_go = 1'b1;
			cps_pkg::ST_CAPTURE: capture  = 1'b1;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cps_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// point count, set flags, pair indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			ovf_res_q <= 1'b0;
			found_q   <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			if (last_acc) begin
				// close the set and start a fresh one behind it
				cnt_q     <= '0;
				ovf_q     <= 1'b0;
				n_q       <= cnt_next;
				ovf_res_q <= ovf_q | cnt_full;
				found_q   <= cnt_next >= cps_pkg::CNT_BITS'(2);
				i_q       <= '0;
				j_q       <= cps_pkg::IDX_BITS'(1);
			end else if (in_acc) begin
				cnt_q <= cnt_next;
				if (cnt_full) begin
					ovf_q <= 1'b1;
				end
			end
			if (issue && !pair_last) begin
				if (j_end) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + cps_pkg::IDX_BITS'(2);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	// two copies of the store so that both points of a pair are read at once
	assign raddr_a = fetch_go ? best_first_q : i_q;
	assign raddr_b = fetch_go ? best_second_q : j_q;

	cps_ram #(
		.WIDTH(cps_pkg::WORD_BITS),
		.DEPTH(cps_pkg::MAX_POINTS)
	) u_store_a (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[cps_pkg::IDX_BITS-1:0]),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	cps_ram #(
		.WIDTH(cps_pkg::WORD_BITS),
		.DEPTH(cps_pkg::MAX_POINTS)
	) u_store_b (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[cps_pkg::IDX_BITS-1:0]),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign ax_s1 = rdata_a[cps_pkg::COORD_BITS-1:0];
	assign ay_s1 = rdata_a[cps_pkg::WORD_BITS-1:cps_pkg::COORD_BITS];
	assign bx_s1 = rdata_b[cps_pkg::COORD_BITS-1:0];
	assign by_s1 = rdata_b[cps_pkg::WORD_BITS-1:cps_pkg::COORD_BITS];

	// pair token follows the ram read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1.valid  <= issue;
			tok_s1.first  <= i_q;
			tok_s1.second <= j_q;
		end
	end

	cps_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_s1  (tok_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (ay_s1),
		.bx_s1   (bx_s1),
		.by_s1   (by_s1),
		.tok_s3  (tok_s3),
		.dist_s3 (dist_s3),
		.busy    (unit_busy)
	);

	// running best; strict less-than keeps the earliest pair on a tie,
	// the first pair of a search is always taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_first_q  <= '0;
			best_second_q <= '0;
			best_dist_q   <= '0;
			best_any_q    <= 1'b0;
		end else begin
			if (last_acc) begin
				best_any_q <= 1'b0;
			end else if (tok_s3.valid && (!best_any_q || dist_s3 < best_dist_q)) begin
				best_any_q    <= 1'b1;
				best_first_q  <= tok_s3.first;
				best_second_q <= tok_s3.second;
				best_dist_q   <= dist_s3;
			end
		end
	end

	// result register, loaded with the coordinates fetched at the best indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (capture) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_q          <= '0;
			out_q.found    <= found_q;
			out_q.overflow <= ovf_res_q;
			if (found_q) begin
				out_q.first_index  <= 6'(best_first_q);
				out_q.second_index <= 6'(best_second_q);
				out_q.first_x      <= 16'(ax_s1);
				out_q.first_y      <= 16'(ay_s1);
				out_q.second_x     <= 16'(bx_s1);
				out_q.second_y     <= 16'(by_s1);
				out_q.min_dist_sq  <= 33'(best_dist_q);
			end
		end
	end

	assign points.ready = in_ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

@@ hdl/cps_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies

module cps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/cps_dist_unit.sv @@
// pipelined squared distance unit: abs difference stage, square stage, sum at the output
// depends on cps_pkg

module cps_dist_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  cps_pkg::pair_tok_t tok_s1,
	input  cps_pkg::coord_t    ax_s1,
	input  cps_pkg::coord_t    ay_s1,
	input  cps_pkg::coord_t    bx_s1,
	input  cps_pkg::coord_t    by_s1,
	output cps_pkg::pair_tok_t tok_s3,
	output cps_pkg::dist_t     dist_s3,
	output logic               busy
);

	logic signed [cps_pkg::COORD_BITS:0] diff_x, diff_y;
	logic [cps_pkg::DIFF_BITS-1:0]       dx, dy;
	logic [cps_pkg::DIFF_BITS-1:0]       dx_s2, dy_s2;
	logic [cps_pkg::SQ_BITS-1:0]         sqx_s3, sqy_s3;
	cps_pkg::pair_tok_t                  tok_s2;

	always_comb begin
		diff_x = (cps_pkg::COORD_BITS+1)'(ax_s1) - (cps_pkg::COORD_BITS+1)'(bx_s1);
		diff_y = (cps_pkg::COORD_BITS+1)'(ay_s1) - (cps_pkg::COORD_BITS+1)'(by_s1);
		dx = diff_x[cps_pkg::COORD_BITS] ? cps_pkg::DIFF_BITS'(-diff_x)
			: cps_pkg::DIFF_BITS'(diff_x);
		dy = diff_y[cps_pkg::COORD_BITS] ? cps_pkg::DIFF_BITS'(-diff_y)
			: cps_pkg::DIFF_BITS'(diff_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else begin
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= dx;
		dy_s2  <= dy;
		sqx_s3 <= cps_pkg::SQ_BITS'(dx_s2) * cps_pkg::SQ_BITS'(dx_s2);
		sqy_s3 <= cps_pkg::SQ_BITS'(dy_s2) * cps_pkg::SQ_BITS'(dy_s2);
	end

	assign dist_s3 = cps_pkg::DIST_BITS'(sqx_s3) + cps_pkg::DIST_BITS'(sqy_s3);
	assign busy    = tok_s2.valid | tok_s3.valid;

endmodule

@@ hdl/cps_checker.sv @@
// port-level checks for closest_pair_search, bound to the top level
// depends on cps_pkg and closest_pair_search

module cps_port_asserts (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [5:0]  first_index,
	input logic [5:0]  second_index,
	input logic [32:0] min_dist_sq
);

	// a result waits until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// the closing transfer starts the search, so no point is taken next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("points accepted during search");

	// a plain point never produces a result by itself
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last && !out_valid |=> !out_valid)
		else $error("result without a closing point");

	// pair order in a found result
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found && (cps_pkg::MAX_POINTS <= 64) |-> second_index > first_index)
		else $error("pair indices out of order");

	// empty result carries zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (min_dist_sq == '0) && (first_index == '0)
			&& (second_index == '0))
		else $error("empty result not cleared");

endmodule

bind closest_pair_search cps_port_asserts u_cps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (points.valid),
	.in_ready     (points.ready),
	.in_last      (points.data.last_point),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.found        (result.data.found),
	.first_index  (result.data.first_index),
	.second_index (result.data.second_index),
	.min_dist_sq  (result.data.min_dist_sq)
);

@@ verif/cps_checker.sv @@
`timescale 1ns / 100ps
// result checker for closest_pair_search: mirrors the point store and predicts each search result
// depends on cps_pkg; watches both channels of the block and hands back a failure count

module cps_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             point_valid,
	input  logic             point_ready,
	input  cps_pkg::point_t  point_data,
	input  logic             result_valid,
	input  logic             result_ready,
	input  cps_pkg::result_t result_data,
	output int               fail_count,
	output int               pending
);
	import cps_pkg::*;

	coord_t  set_x [MAX_POINTS];
	coord_t  set_y [MAX_POINTS];
	int      set_size;
	logic    set_dropped;
	result_t closest_q [$];
	int      errors = 0;

	function automatic longint unsigned pair_dist(int a, int b);
		longint dx;
		longint dy;
		dx = longint'(set_x[a]) - longint'(set_x[b]);
		dy = longint'(set_y[a]) - longint'(set_y[b]);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return dx * dx + dy * dy;
	endfunction

	// full search, i outer and j inner, strict less-than keeps the earliest of a tie
	function automatic result_t closest_pair();
		result_t         r;
		longint unsigned best;
		longint unsigned d;
		int              bi;
		int              bj;
		r = '0;
		r.overflow = set_dropped;
		if (set_size >= 2) begin
			bi = 0;
			bj = 1;
			best = pair_dist(0, 1);
			for (int i = 0; i + 1 < set_size; i++) begin
				for (int j = i + 1; j < set_size; j++) begin
					d = pair_dist(i, j);
					if (d < best) begin
						best = d;
						bi = i;
						bj = j;
					end
				end
			end
			r.found        = 1'b1;
			r.first_index  = 6'(bi);
			r.second_index = 6'(bj);
			r.first_x      = set_x[bi];
			r.first_y      = set_y[bi];
			r.second_x     = set_x[bj];
			r.second_y     = set_y[bj];
			r.min_dist_sq  = 33'(best);
		end
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			set_size = 0;
			set_dropped = 1'b0;
		end else begin
			if (point_valid && point_ready) begin
				if (set_size < MAX_POINTS) begin
					set_x[set_size] = coord_t'(point_data.point_x);
					set_y[set_size] = coord_t'(point_data.point_y);
					set_size++;
				end else begin
					set_dropped = 1'b1;
				end
				if (point_data.last_point) begin
					closest_q.push_back(closest_pair());
					set_size = 0;
					set_dropped = 1'b0;
				end
			end
			if (result_valid && result_ready) begin
				if (closest_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h", $time,
						result_data);
				end else begin
					want = closest_q.pop_front();
					check_field("found", want.found, result_data.found);
					check_field("first_index", want.first_index, result_data.first_index);
					check_field("second_index", want.second_index, result_data.second_index);
					check_field("first_x", want.first_x, result_data.first_x);
					check_field("first_y", want.first_y, result_data.first_y);
					check_field("second_x", want.second_x, result_data.second_x);
					check_field("second_y", want.second_y, result_data.second_y);
					check_field("min_dist_sq", want.min_dist_sq, result_data.min_dist_sq);
					check_field("overflow", want.overflow, result_data.overflow);
				end
			end
		end
		fail_count <= errors;
		pending    <= closest_q.size();
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// testbench top for closest_pair_search: clock, reset, point sets and result back-pressure
// depends on cps_pkg, cps_point_if, cps_result_if, closest_pair_search and cps_checker

module tb_top;
	import cps_pkg::*;

	// how the coordinates of one set are drawn
	typedef enum int {
		COORD_WIDE,
		COORD_CLUSTER,
		COORD_CORNER,
		COORD_MIXED
	} coord_mix_t;

	localparam int RANDOM_ITEMS    = 750;
	localparam int CALM_TAIL_ITEMS = 80;
	localparam int HOLD_CYCLES     = 4000;
	localparam int TAIL_CYCLES     = 40;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   hold_req  = 1'b0;  // asks the result side for one long hold-off
	bit   calm_tail = 1'b0;  // last part of the run: no idling on either side
	int   sent_items = 0;
	int   calm_left  = 0;    // transfers still to go in a stretch with no sender gaps

	cps_point_if  points_ch ();
	cps_result_if result_ch ();

	closest_pair_search u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points_ch),
		.result (result_ch)
	);

	cps_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (points_ch.valid),
		.point_ready  (points_ch.ready),
		.point_data   (points_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// one point transfer, with a random gap in front of it now and then
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic last);
		point_t p;
		p.point_x    = x;
		p.point_y    = y;
		p.last_point = last;
		if (calm_left > 0) begin
			calm_left--;
		end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
			points_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end else if ($urandom_range(0, 19) == 0) begin
			calm_left = $urandom_range(10, 60);
		end
		points_ch.valid <= 1'b1;
		points_ch.data  <= p;
		// valid stays up through the search, when the block holds ready low
		do @(posedge clk); while (!points_ch.ready);
		sent_items++;
	endtask

	function automatic logic signed [15:0] pick_coord(coord_mix_t mix,
		logic signed [15:0] center);
		logic signed [15:0] corner_vals [7];
		coord_mix_t         m;
		corner_vals = '{16'sh8000, 16'sh8001, 16'shffff, 16'sh0000, 16'sh0001,
			16'sh7ffe, 16'sh7fff};
		m = mix;
		if (m == COORD_MIXED) m = coord_mix_t'($urandom_range(0, 2));
		case (m)
			// a tight cloud, so near ties and duplicates are common; wraps at the range ends
			COORD_CLUSTER: return 16'(center + $urandom_range(0, 16) - 8);
			COORD_CORNER:  return corner_vals[$urandom_range(0, 6)];
			default:       return 16'($urandom);
		endcase
	endfunction

	task automatic send_set(input int n, input coord_mix_t mix);
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		cx = 16'($urandom);
		cy = 16'($urandom);
		for (int k = 0; k < n; k++) begin
			send_point(pick_coord(mix, cx), pick_coord(mix, cy), k == n - 1);
		end
	endtask

	// result side: short stalls, calm stretches, one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long enough that a finished result blocks the next set and the input stalls
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30)) @(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int         rand_start;
		int         set_no;
		int         n;
		int         r;
		coord_mix_t mix;

		arst_n <= 1'b0;
		points_ch.valid <= 1'b0;
		points_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// a lone point: nothing to pair, found stays low
		send_point(16'sh7fff, 16'sh8000, 1'b1);
		// opposite corners: the largest distance there is
		send_point(16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh7fff, 1'b1);
		// equal distances in a row: the first pair wins
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b0);
		send_point(16'sd2, 16'sd0, 1'b1);
		// tie across outer indices: (0,2) before (1,3)
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd10, 16'sd0, 1'b0);
		send_point(16'sd3, 16'sd0, 1'b0);
		send_point(16'sd13, 16'sd0, 1'b1);
		// duplicate points, zero distance
		send_point(-16'sd5, 16'sd7, 1'b0);
		send_point(16'sd100, -16'sd100, 1'b0);
		send_point(-16'sd5, 16'sd7, 1'b1);
		// closest pair at the end of the scan
		send_point(16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh8001, 1'b1);
		// alternating bit patterns
		send_point(16'sh5555, 16'shaaaa, 1'b0);
		send_point(16'shaaaa, 16'sh5555, 1'b1);

		// random sets; the first ones meet the long result hold-off
		hold_req = 1'b1;
		rand_start = sent_items;
		set_no = 0;
		while (sent_items - rand_start < RANDOM_ITEMS) begin
			if (sent_items - rand_start >= RANDOM_ITEMS - CALM_TAIL_ITEMS) calm_tail = 1'b1;
			r = $urandom_range(0, 19);
			// an exactly full store, then one that drops points and its flagged last one
			if (set_no == 5) n = MAX_POINTS;
			else if (set_no == 6) n = MAX_POINTS + 3;
			else if (r == 0) n = $urandom_range(MAX_POINTS - 2, MAX_POINTS + 6);
			else if (r < 3) n = $urandom_range(13, 40);
			else n = $urandom_range(1, 12);
			mix = coord_mix_t'($urandom_range(0, 3));
			send_set(n, mix);
			set_no++;
		end
		points_ch.valid <= 1'b0;

		// let the checker see the last transfer, then wait for the last search
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
